FILE: rtl/core/pbfa_pkg.sv
package pbfa_pkg;

  // Field widths of the channels and the configuration register
  localparam int TP_W      = 13;
  localparam int CNT_W     = 13;
  localparam int ADDR_W    = 24;
  localparam int FIRST_W   = 12;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [TP_W-1:0] TP_RESET = 13'd4096;

  localparam int PAGES_DEF      = 4096;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [CNT_W-1:0]   count;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [FIRST_W-1:0] first_page;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_FREE_CHK,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } pbfa_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_en;
    logic load;
    logic div_step;
    logic scan_init;
    logic scan_step;
    logic mark_init;
    logic mark_step;
    logic res_ok;
    logic res_miss;
  } pbfa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic cnt_zero;
    logic free_empty;
    logic scan_hit;
    logic scan_miss;
    logic mark_done;
  } pbfa_sts_t;

endpackage

FILE: rtl/core/pbfa_ram.sv
module pbfa_ram import pbfa_pkg::*; #(
  parameter  int WIDTH = WORD_BITS,
  parameter  int DEPTH = PAGES_DEF / WORD_BITS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/pbfa_datapath.sv
module pbfa_datapath import pbfa_pkg::*; #(
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pbfa_cmd_t       cmd,
  output pbfa_sts_t       sts,
  input  in_item_t        in_item,
  input  logic            cfg_wr_en,
  input  logic [TP_W-1:0] cfg_wr_data,
  output out_item_t       out_item
);

  localparam int MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNTW      = $clog2(MAP_WORDS + 1);

  // Rounded-up reciprocal of PAGE_BYTES, exact for every address
  localparam int                DIV_SH  = ADDR_W + $clog2(PAGE_BYTES);
  localparam int                DIV_MW  = ADDR_W + 1;
  localparam int                PRD_W   = ADDR_W + DIV_MW;
  localparam logic [63:0]       DIV_NUM = 64'd1 << DIV_SH;
  localparam logic [DIV_MW-1:0] DIV_M   =
    DIV_MW'((DIV_NUM + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

  // Configuration and captured request
  logic [TP_W-1:0]    tp_r;
  logic               cmd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ADDR_W-1:0]  dq_r;
  logic [AW-1:0]      clr_ptr_r;

  // Scan pipeline
  logic [TP_W-1:0]    lim_r;
  logic [CNTW-1:0]    lim_words_r;
  logic [CNTW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]   run_r;
  logic               rvalid_r;
  logic [AW-1:0]      rword_r;
  logic [WORD_BITS-1:0] hvec_r;
  logic               hvalid_r;
  logic [AW-1:0]      hword_r;

  // Marking pass
  logic [AW-1:0]      lo_word_r, hi_word_r, mp_r, mw_r;
  logic [BIT_W-1:0]   lo_bit_r, hi_bit_r;
  logic               mk_issue_r, mvalid_r;

  logic               res_found_r;
  logic [FIRST_W-1:0] res_first_r;

  logic [WORD_BITS-1:0] rd_data, wr_data, hit_v, merged, mmask;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;

  pbfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Address to page index: one reciprocal multiply and a shift
  logic [PRD_W-1:0]  dprod;
  logic [ADDR_W-1:0] dq_nxt;

  always_comb begin
    dprod  = PRD_W'(dq_r) * PRD_W'(DIV_M);
    dq_nxt = ADDR_W'(dprod >> DIV_SH);
  end

  // Scan limit
  logic [TP_W-1:0] lim;
  logic [31:0]     lim_words32;

  always_comb begin
    lim = (32'(tp_r) < 32'(PAGES)) ? tp_r : TP_W'(PAGES);
    lim_words32 = (32'(lim) + 32'(WORD_BITS - 1)) >> BIT_W;
  end

  logic scan_issue;
  assign scan_issue = cmd.scan_step && (rd_ptr_r < lim_words_r);

  // Hit vector: bit p set where a run of cnt_r free pages ends at page p
  logic [WORD_BITS-1:0] thr, fr, valid_m;

  always_comb begin
    int          p;
    int          q;
    logic [31:0] lowm;
    logic [31:0] wm;
    logic        pre;
    logic        loc;
    logic        sumok;
    fr = ~rd_data;
    for (p = 0; p < WORD_BITS; p++) begin
      thr[p] = cnt_r > CNT_W'(p);
    end
    if (32'(rword_r) < 32'(lim_r[TP_W-1:BIT_W])) begin
      valid_m = '1;
    end else if (32'(rword_r) == 32'(lim_r[TP_W-1:BIT_W])) begin
      valid_m = (32'h1 << lim_r[BIT_W-1:0]) - 32'h1;
    end else begin
      valid_m = '0;
    end
    for (p = 0; p < WORD_BITS; p++) begin
      lowm = 32'hFFFF_FFFF >> (WORD_BITS - 1 - p);
      pre  = &(fr | ~lowm);
      wm   = '0;
      for (q = 0; q <= p; q++) begin
        wm[q] = thr[p-q];
      end
      loc   = (32'(cnt_r) <= 32'(p + 1)) && (&(fr | ~wm));
      sumok = ({1'b0, run_r} + (CNT_W + 1)'(p + 1)) >= {1'b0, cnt_r};
      hit_v[p] = valid_m[p] && (loc || (pre && sumok));
    end
  end

  // Free pages at the top of the word carry into the next one
  logic [BIT_W-1:0] topfree;
  logic [CNT_W:0]   run_sum;
  logic [CNT_W-1:0] run_nxt;

  always_comb begin
    int q;
    topfree = '0;
    for (q = 0; q < WORD_BITS; q++) begin
      if (rd_data[q]) begin
        topfree = BIT_W'(WORD_BITS - 1 - q);
      end
    end
    run_sum = {1'b0, run_r} + (CNT_W + 1)'(WORD_BITS);
    if (rd_data == '0) begin
      run_nxt = run_sum[CNT_W] ? '1 : run_sum[CNT_W-1:0];
    end else begin
      run_nxt = CNT_W'(topfree);
    end
  end

  // Lowest hit of the first word with one, and the run it closes
  logic [BIT_W-1:0] fidx;
  logic [31:0]      end32, beg32, q32, fend32, lo32, hi32;
  logic             free_empty;

  always_comb begin
    int p;
    fidx = '0;
    for (p = WORD_BITS - 1; p >= 0; p--) begin
      if (hvec_r[p]) begin
        fidx = BIT_W'(p);
      end
    end
    end32 = (32'(hword_r) << BIT_W) | 32'(fidx);
    beg32 = end32 + 32'h1 - 32'(cnt_r);
    q32   = 32'(dq_r);
    fend32 = q32 + 32'(cnt_r) - 32'h1;
    if (fend32 > 32'(PAGES - 1)) begin
      fend32 = 32'(PAGES - 1);
    end
    free_empty = (cnt_r == '0) || (q32 >= 32'(PAGES));
    if (cmd_r == CMD_ALLOC) begin
      lo32 = beg32;
      hi32 = end32;
    end else begin
      lo32 = q32;
      hi32 = fend32;
    end
  end

  // Marking mask for the word coming back from the map
  always_comb begin
    int q;
    logic [BIT_W-1:0] lb;
    logic [BIT_W-1:0] hb;
    lb = (mw_r == lo_word_r) ? lo_bit_r : '0;
    hb = (mw_r == hi_word_r) ? hi_bit_r : BIT_W'(WORD_BITS - 1);
    for (q = 0; q < WORD_BITS; q++) begin
      mmask[q] = (BIT_W'(q) >= lb) && (BIT_W'(q) <= hb);
    end
    merged = (cmd_r == CMD_ALLOC) ? (rd_data | mmask) : (rd_data & ~mmask);
  end

  // Map port muxing
  always_comb begin
    rd_addr = cmd.mark_step ? mp_r : rd_ptr_r[AW-1:0];
    if (cmd.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_ptr_r;
      wr_data = '1;
    end else begin
      wr_en   = mvalid_r;
      wr_addr = mw_r;
      wr_data = merged;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r       <= TP_RESET;
      clr_ptr_r  <= '0;
      rvalid_r   <= 1'b0;
      hvalid_r   <= 1'b0;
      mk_issue_r <= 1'b0;
      mvalid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tp_r <= cfg_wr_data;
      end
      if (cmd.clr_en) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
      end
      rvalid_r <= scan_issue;
      hvalid_r <= cmd.scan_step && rvalid_r;
      if (cmd.mark_init) begin
        mk_issue_r <= 1'b1;
      end else if (cmd.mark_step && mk_issue_r && (mp_r == hi_word_r)) begin
        mk_issue_r <= 1'b0;
      end
      mvalid_r <= cmd.mark_step && mk_issue_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item.command;
      cnt_r <= in_item.count;
      dq_r  <= in_item.address;
    end else if (cmd.div_step) begin
      dq_r  <= dq_nxt;
    end
    if (cmd.scan_init) begin
      lim_r       <= lim;
      lim_words_r <= CNTW'(lim_words32);
      rd_ptr_r    <= '0;
      run_r       <= '0;
    end else begin
      if (scan_issue) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (rvalid_r) begin
        run_r <= run_nxt;
      end
    end
    rword_r <= rd_ptr_r[AW-1:0];
    hvec_r  <= hit_v;
    hword_r <= rword_r;
    if (cmd.mark_init) begin
      lo_word_r <= AW'(lo32 >> BIT_W);
      hi_word_r <= AW'(hi32 >> BIT_W);
      lo_bit_r  <= lo32[BIT_W-1:0];
      hi_bit_r  <= hi32[BIT_W-1:0];
      mp_r      <= AW'(lo32 >> BIT_W);
    end else if (cmd.mark_step && mk_issue_r && (mp_r != hi_word_r)) begin
      mp_r <= mp_r + 1'b1;
    end
    mw_r <= mp_r;
    if (cmd.res_ok) begin
      res_found_r <= 1'b1;
      res_first_r <= (cmd_r == CMD_ALLOC) ? beg32[FIRST_W-1:0] : '0;
    end else if (cmd.res_miss) begin
      res_found_r <= 1'b0;
      res_first_r <= '0;
    end
  end

  always_comb begin
    sts.clr_last   = 32'(clr_ptr_r) == 32'(MAP_WORDS - 1);
    sts.is_free    = cmd_r == CMD_FREE;
    sts.cnt_zero   = cnt_r == '0;
    sts.free_empty = free_empty;
    sts.scan_hit   = hvalid_r && (hvec_r != '0);
    sts.scan_miss  = (rd_ptr_r >= lim_words_r) && !rvalid_r && !hvalid_r;
    sts.mark_done  = mvalid_r && (mw_r == hi_word_r);
  end

  assign out_item = '{found: res_found_r, first_page: res_first_r};

endmodule

FILE: rtl/core/pbfa_ctrl.sv
module pbfa_ctrl import pbfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  pbfa_sts_t sts,
  output pbfa_cmd_t cmd,
  output logic      busy,
  output logic      out_strobe
);

  pbfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_free) begin
          state_nxt = ST_DIV;
        end else if (sts.cnt_zero) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        cmd.res_ok = 1'b1;
        if (sts.free_empty) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mark_init = 1'b1;
          state_nxt     = ST_MARK;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) begin
          cmd.mark_init = 1'b1;
          cmd.res_ok    = 1'b1;
          state_nxt     = ST_MARK;
        end else if (sts.scan_miss) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/page_bitmap_first_fit_allocator.sv
// First-fit contiguous page allocator over a one-bit-per-page usage map
// (set bit = used). The map lives in a single word-wide RAM, 32 pages a word.
// Request channel: present in_item while raising start; the beat is taken at
// the edge where start is high and busy is low. command ALLOC finds the
// lowest run of count free pages below min(total_pages, PAGES) and marks it
// used; command FREE divides address by PAGE_BYTES and clears count pages
// from there, dropping any page at or past PAGES.
// Result channel: out_item is valid in the single cycle out_strobe is high;
// the receiver cannot stall, so take it then. found=0 carries first_page=0.
// Allocate scans one map word a cycle through a two-stage hit pipeline,
// then marks one word a cycle (read, then write back); a miss ends with
// the scan. Free turns the address into a page with one reciprocal
// multiply, then marks, and skips marking when nothing is cleared.
// Zero-count allocate returns a miss without scanning. One request is in
// flight at a time; the next is taken in the cycle after the strobe at the
// earliest. Reset: total_pages returns to 4096 and a clearing pass writes
// every map word to all ones, one word a cycle; busy stays high until it
// ends. Write cfg only when idle.
module page_bitmap_first_fit_allocator import pbfa_pkg::*; #(
  parameter int PAGES      = PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_item,
  output logic            out_strobe,
  output out_item_t       out_item,
  input  logic            cfg_wr_en,
  input  logic [TP_W-1:0] cfg_wr_data
);

  pbfa_cmd_t cmd;
  pbfa_sts_t sts;

  // Sequencer: clearing pass, divide, scan, mark, respond
  pbfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // Map RAM, divider, scan pipeline and marking pipeline
  pbfa_datapath #(
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_item    (out_item)
  );

  // A result beat lasts exactly one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // An accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a request");

  // A miss reports page zero
  a_miss_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.found) |-> (out_item.first_page == '0))
    else $error("not-found result with nonzero first page");

  // No result while the block is idle
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

endmodule
